// ----- rtl/mark_smallest_unmarked_sum_assert.svh -----
// Assertion macros used by mssum_back of mark_smallest_unmarked_sum.
`ifndef MARK_SMALLEST_UNMARKED_SUM_ASSERT_SVH
`define MARK_SMALLEST_UNMARKED_SUM_ASSERT_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define MSSUM_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define MSSUM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/mssum_pkg.sv -----
// Package with the shared types and constants of mark_smallest_unmarked_sum.
package mssum_pkg;

  // Fixed widths of the item and result fields.
  localparam int FUNC_W  = 2;
  localparam int LOAD_W  = 16;
  localparam int QIDX_W  = 6;
  localparam int KCNT_W  = 7;
  localparam int TOTAL_W = 22;

  // Function codes on the func port.
  localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_LOAD  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_QUERY = 2'd2;

  // Depth of the queue between the front and back parts.
  localparam int QUEUE_DEPTH = 2;

  // Decoded operation carried through the queue.
  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_LOAD  = 2'd1,
    OP_QUERY = 2'd2
  } op_t;

  // One decoded item.
  typedef struct packed {
    op_t               op;
    logic [LOAD_W-1:0] load_value;
    logic [QIDX_W-1:0] query_index;
    logic [KCNT_W-1:0] mark_count;
  } item_t;

  // Queue status seen by both sides.
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

// ----- rtl/mark_smallest_unmarked_sum.sv -----
// Top level of mark_smallest_unmarked_sum.
//
// Items enter on start/busy: an item is taken at a clock edge where start is
// high and busy is low. func selects clear (0), load (1) or query (2); other
// codes are dropped. A query produces one result: done is high for exactly one
// cycle with unmarked_total valid. Clear and load produce no result. The
// receiver cannot stall; each result must be taken in its cycle.
// A front stage and a two-entry queue take items while the back part works.
// The back part keeps the table sorted by value. A clear is applied as it is
// popped. A load into a non-empty table walks down the sorted-list memory
// port one rank at a time (read, then compare; larger entries move up a rank)
// and then writes the new entry. A query first marks its index when that is
// loaded, then walks the sorted ranks (read, mark read, update per rank).
// The walk pointer moves forward between clears, and a load sorted below it
// pulls it back to the new rank; ranks below the pointer are all marked and
// are not visited. Items pass the registered front stage and the queue.
// Reset empties the table and the queue; no memory clearing pass is needed,
// since marks are written as each entry is loaded.
module mark_smallest_unmarked_sum #(
  parameter int ENTRIES    = 64,
  parameter int VALUE_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic [mssum_pkg::FUNC_W-1:0]   func,
  input  logic [mssum_pkg::LOAD_W-1:0]   load_value,
  input  logic [mssum_pkg::QIDX_W-1:0]   query_index,
  input  logic [mssum_pkg::KCNT_W-1:0]   mark_count,
  output logic                           done,
  output logic [mssum_pkg::TOTAL_W-1:0]  unmarked_total
);

  logic                 push;
  logic                 pop;
  mssum_pkg::item_t     push_item;
  mssum_pkg::item_t     head;
  mssum_pkg::q_status_t qs;

  // Front part.
  mssum_front u_front (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .func        (func),
    .load_value  (load_value),
    .query_index (query_index),
    .mark_count  (mark_count),
    .qs          (qs),
    .push        (push),
    .push_item   (push_item)
  );

  // Queue between the parts.
  mssum_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head      (head),
    .qs        (qs)
  );

  // Back part.
  mssum_back #(
    .ENTRIES    (ENTRIES),
    .VALUE_BITS (VALUE_BITS)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .head           (head),
    .qs             (qs),
    .pop            (pop),
    .done           (done),
    .unmarked_total (unmarked_total)
  );

endmodule

// ----- rtl/mssum_front.sv -----
// Front part: accepts items, drops unused function codes and feeds the queue.
module mssum_front (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  logic [mssum_pkg::FUNC_W-1:0]     func,
  input  logic [mssum_pkg::LOAD_W-1:0]     load_value,
  input  logic [mssum_pkg::QIDX_W-1:0]     query_index,
  input  logic [mssum_pkg::KCNT_W-1:0]     mark_count,
  input  mssum_pkg::q_status_t             qs,
  output logic                             push,
  output mssum_pkg::item_t                 push_item
);

  logic             accept;
  logic             legal;
  mssum_pkg::op_t   dec_op;
  logic             stage_valid;
  mssum_pkg::item_t stage;

  // Decode the function code; unused codes are dropped here.
  always_comb begin
    legal  = 1'b1;
    dec_op = mssum_pkg::OP_CLEAR;
    case (func)
      mssum_pkg::FUNC_CLEAR: dec_op = mssum_pkg::OP_CLEAR;
      mssum_pkg::FUNC_LOAD:  dec_op = mssum_pkg::OP_LOAD;
      mssum_pkg::FUNC_QUERY: dec_op = mssum_pkg::OP_QUERY;
      default:               legal  = 1'b0;
    endcase
  end

  // The stage holds one item while the queue is full.
  assign busy      = stage_valid & qs.full;
  assign accept    = start & ~busy;
  assign push      = stage_valid & ~qs.full;
  assign push_item = stage;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (accept) begin
      stage_valid <= legal;
    end else if (push) begin
      stage_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      stage.op          <= dec_op;
      stage.load_value  <= load_value;
      stage.query_index <= query_index;
      stage.mark_count  <= mark_count;
    end
  end

endmodule

// ----- rtl/mssum_fifo.sv -----
// Short queue of decoded items between the front and back parts.
module mssum_fifo (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  mssum_pkg::item_t     push_item,
  input  logic                 pop,
  output mssum_pkg::item_t     head,
  output mssum_pkg::q_status_t qs
);

  localparam int PTR_W = (mssum_pkg::QUEUE_DEPTH > 1) ? $clog2(mssum_pkg::QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(mssum_pkg::QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(mssum_pkg::QUEUE_DEPTH - 1);

  mssum_pkg::item_t slots [mssum_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] fill;

  assign qs.full  = (fill == CNT_W'(mssum_pkg::QUEUE_DEPTH));
  assign qs.empty = (fill == '0);
  assign head     = slots[rd_ptr];

  // Pointer and fill bookkeeping.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        fill <= fill + CNT_W'(1);
      end else if (pop && !push) begin
        fill <= fill - CNT_W'(1);
      end
    end
  end

  // Item storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

endmodule

// ----- rtl/mssum_back.sv -----
// Back part: keeps the table in value order and marks entries on queries.
`include "mark_smallest_unmarked_sum_assert.svh"

module mssum_back #(
  parameter int ENTRIES    = 64,
  parameter int VALUE_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  mssum_pkg::item_t                  head,
  input  mssum_pkg::q_status_t              qs,
  output logic                              pop,
  output logic                              done,
  output logic [mssum_pkg::TOTAL_W-1:0]     unmarked_total
);

  localparam int IDX_W  = $clog2(ENTRIES);
  localparam int CNT_W  = $clog2(ENTRIES + 1);
  localparam int CMP_W  = (CNT_W > mssum_pkg::QIDX_W) ? CNT_W : mssum_pkg::QIDX_W;
  localparam int SORT_W = VALUE_BITS + IDX_W;
  localparam int TW     = mssum_pkg::TOTAL_W;

  typedef enum logic [7:0] {
    S_IDLE     = 8'b0000_0001,
    S_INS_RD   = 8'b0000_0010,
    S_INS_CMP  = 8'b0000_0100,
    S_INS_PUT  = 8'b0000_1000,
    S_Q_IDX    = 8'b0001_0000,
    S_WALK_RD  = 8'b0010_0000,
    S_WALK_MK  = 8'b0100_0000,
    S_WALK_UPD = 8'b1000_0000
  } state_t;

  // Control registers.
  state_t           state, state_next;
  logic [CNT_W-1:0] count, count_next;
  logic [TW-1:0]    total, total_next;
  logic [CNT_W-1:0] ptr, ptr_next;
  logic             done_next;

  // Payload registers.
  logic [IDX_W-1:0]         pos, pos_next;
  logic [IDX_W-1:0]         put_pos, put_pos_next;
  logic [VALUE_BITS-1:0]    new_val, new_val_next;
  logic [IDX_W-1:0]         new_idx, new_idx_next;
  logic [IDX_W-1:0]         q_idx, q_idx_next;
  logic [mssum_pkg::KCNT_W-1:0] kleft, kleft_next;
  logic [SORT_W-1:0]        walk_ent, walk_ent_next;
  logic [TW-1:0]            result_next;

  // Memories: values by load index, marks by load index, sorted list by rank.
  logic [VALUE_BITS-1:0] value_mem [ENTRIES];
  logic                  mark_mem  [ENTRIES];
  logic [SORT_W-1:0]     sort_mem  [ENTRIES];

  logic                  value_we;
  logic [IDX_W-1:0]      value_wa, value_ra;
  logic [VALUE_BITS-1:0] value_wd, value_q;
  logic                  mark_we, mark_wd, mark_q;
  logic [IDX_W-1:0]      mark_wa, mark_ra;
  logic                  sort_we;
  logic [IDX_W-1:0]      sort_wa, sort_ra;
  logic [SORT_W-1:0]     sort_wd, sort_q;

  logic [VALUE_BITS-1:0] head_val;
  logic [CMP_W-1:0]      idx_ext;
  logic [CMP_W-1:0]      cnt_ext;

  // Keep only the low VALUE_BITS bits of the loaded value.
  if (VALUE_BITS >= mssum_pkg::LOAD_W) begin : g_wide
    assign head_val = VALUE_BITS'(head.load_value);
  end else begin : g_narrow
    assign head_val = head.load_value[VALUE_BITS-1:0];
  end

  assign idx_ext = CMP_W'(head.query_index);
  assign cnt_ext = CMP_W'(count);

  // Sequencer for clears, loads (insertion into the sorted list) and queries (walk).
  always_comb begin
    state_next    = state;
    count_next    = count;
    total_next    = total;
    ptr_next      = ptr;
    done_next     = 1'b0;
    pos_next      = pos;
    put_pos_next  = put_pos;
    new_val_next  = new_val;
    new_idx_next  = new_idx;
    q_idx_next    = q_idx;
    kleft_next    = kleft;
    walk_ent_next = walk_ent;
    result_next   = unmarked_total;
    pop           = 1'b0;
    value_we      = 1'b0;
    value_wa      = count[IDX_W-1:0];
    value_wd      = head_val;
    value_ra      = q_idx;
    mark_we       = 1'b0;
    mark_wa       = count[IDX_W-1:0];
    mark_wd       = 1'b0;
    mark_ra       = q_idx;
    sort_we       = 1'b0;
    sort_wa       = pos;
    sort_wd       = sort_q;
    sort_ra       = pos;

    case (state)
      S_IDLE: begin
        if (!qs.empty) begin
          pop = 1'b1;
          case (head.op)
            mssum_pkg::OP_CLEAR: begin
              count_next = '0;
              total_next = '0;
              ptr_next   = '0;
            end
            mssum_pkg::OP_LOAD: begin
              if (count != CNT_W'(ENTRIES)) begin
                value_we     = 1'b1;
                mark_we      = 1'b1;
                mark_wd      = 1'b0;
                total_next   = total + TW'(head_val);
                new_val_next = head_val;
                new_idx_next = count[IDX_W-1:0];
                if (count == '0) begin
                  sort_we    = 1'b1;
                  sort_wa    = '0;
                  sort_wd    = {head_val, IDX_W'(0)};
                  count_next = CNT_W'(1);
                  ptr_next   = '0;
                end else begin
                  pos_next   = count[IDX_W-1:0] - IDX_W'(1);
                  state_next = S_INS_RD;
                end
              end
            end
            mssum_pkg::OP_QUERY: begin
              q_idx_next = IDX_W'(head.query_index);
              kleft_next = head.mark_count;
              if (idx_ext < cnt_ext) begin
                mark_ra    = IDX_W'(head.query_index);
                value_ra   = IDX_W'(head.query_index);
                state_next = S_Q_IDX;
              end else begin
                state_next = S_WALK_RD;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_INS_RD: begin
        sort_ra    = pos;
        state_next = S_INS_CMP;
      end
      S_INS_CMP: begin
        // Larger entries move up one rank; equal ones stay ahead of the new one.
        if (sort_q[SORT_W-1 -: VALUE_BITS] > new_val) begin
          sort_we = 1'b1;
          sort_wa = pos + IDX_W'(1);
          sort_wd = sort_q;
          if (pos == '0) begin
            put_pos_next = '0;
            state_next   = S_INS_PUT;
          end else begin
            pos_next   = pos - IDX_W'(1);
            state_next = S_INS_RD;
          end
        end else begin
          put_pos_next = pos + IDX_W'(1);
          state_next   = S_INS_PUT;
        end
      end
      S_INS_PUT: begin
        sort_we    = 1'b1;
        sort_wa    = put_pos;
        sort_wd    = {new_val, new_idx};
        count_next = count + CNT_W'(1);
        // Ranks below the walk pointer are all marked; an insertion there pulls it back.
        if (CNT_W'(put_pos) < ptr) begin
          ptr_next = CNT_W'(put_pos);
        end
        state_next = S_IDLE;
      end
      S_Q_IDX: begin
        if (!mark_q) begin
          mark_we    = 1'b1;
          mark_wa    = q_idx;
          mark_wd    = 1'b1;
          total_next = total - TW'(value_q);
        end
        state_next = S_WALK_RD;
      end
      S_WALK_RD: begin
        if (kleft == '0 || ptr >= count) begin
          done_next   = 1'b1;
          result_next = total;
          state_next  = S_IDLE;
        end else begin
          sort_ra    = ptr[IDX_W-1:0];
          state_next = S_WALK_MK;
        end
      end
      S_WALK_MK: begin
        mark_ra       = sort_q[IDX_W-1:0];
        walk_ent_next = sort_q;
        state_next    = S_WALK_UPD;
      end
      S_WALK_UPD: begin
        if (!mark_q) begin
          mark_we    = 1'b1;
          mark_wa    = walk_ent[IDX_W-1:0];
          mark_wd    = 1'b1;
          total_next = total - TW'(walk_ent[SORT_W-1 -: VALUE_BITS]);
          kleft_next = kleft - mssum_pkg::KCNT_W'(1);
        end
        ptr_next   = ptr + CNT_W'(1);
        state_next = S_WALK_RD;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      total <= '0;
      ptr   <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      total <= total_next;
      ptr   <= ptr_next;
      done  <= done_next;
    end
  end

  // Payload state.
  always_ff @(posedge clk) begin
    pos            <= pos_next;
    put_pos        <= put_pos_next;
    new_val        <= new_val_next;
    new_idx        <= new_idx_next;
    q_idx          <= q_idx_next;
    kleft          <= kleft_next;
    walk_ent       <= walk_ent_next;
    unmarked_total <= result_next;
  end

  // Value memory.
  always_ff @(posedge clk) begin
    if (value_we) begin
      value_mem[value_wa] <= value_wd;
    end
    value_q <= value_mem[value_ra];
  end

  // Mark memory; a read of an entry at or above the loaded count is never used.
  always_ff @(posedge clk) begin
    if (mark_we) begin
      mark_mem[mark_wa] <= mark_wd;
    end
    mark_q <= mark_mem[mark_ra];
  end

  // Sorted list memory holding value and load index per rank.
  always_ff @(posedge clk) begin
    if (sort_we) begin
      sort_mem[sort_wa] <= sort_wd;
    end
    sort_q <= sort_mem[sort_ra];
  end

  `MSSUM_ASSERT_SAME(a_ptr_bound, 1'b1, ptr <= count, "walk pointer beyond loaded count")
  `MSSUM_ASSERT_SAME(a_count_bound, 1'b1, count <= CNT_W'(ENTRIES), "loaded count overflow")
  `MSSUM_ASSERT_SAME(a_done_after_walk, done, $past(state) == S_WALK_RD, "result not from walk")
  `MSSUM_ASSERT_NEXT(a_insert_grows, state == S_INS_PUT, count == $past(count) + CNT_W'(1), "insertion did not grow table")

endmodule

// ----- verif/tb_mark_smallest_unmarked_sum.sv -----
// Self-checking testbench for mark_smallest_unmarked_sum with a built-in predictor.
`timescale 1ns / 1ps

module tb_mark_smallest_unmarked_sum;

  localparam int TABLE_DEPTH = 64;
  localparam int VALUE_W = 16;
  localparam int RANDOM_ITEMS = 800;
  localparam int QUIET_TAIL_ITEMS = 150;
  localparam int DRAIN_CYCLES = 600;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int REPORT_LIMIT = 10;

  // The block drops this func code without any effect.
  localparam logic [mssum_pkg::FUNC_W-1:0] FUNC_UNUSED = 2'd3;

  logic clk = 1'b0;
  logic rst;
  logic start;
  logic busy;
  logic [mssum_pkg::FUNC_W-1:0] func;
  logic [mssum_pkg::LOAD_W-1:0] load_value;
  logic [mssum_pkg::QIDX_W-1:0] query_index;
  logic [mssum_pkg::KCNT_W-1:0] mark_count;
  logic done;
  logic [mssum_pkg::TOTAL_W-1:0] unmarked_total;

  int unsigned item_count;
  int unsigned idle_odds;
  int unsigned cycle_count;
  logic quiet_tail;

  // Tracks the table, the marks and the unmarked sum, and holds the totals
  // that queries still owe.
  class unmarked_sum_tracker;
    logic [VALUE_W-1:0] entry_value [TABLE_DEPTH];
    bit entry_marked [TABLE_DEPTH];
    int unsigned loaded;
    logic [mssum_pkg::TOTAL_W-1:0] total;
    logic [mssum_pkg::TOTAL_W-1:0] pending_totals [$];
    int unsigned errors;

    function new();
      loaded = 0;
      total = '0;
      errors = 0;
      foreach (entry_marked[i]) entry_marked[i] = 1'b0;
    endfunction

    function void strike(int unsigned slot);
      entry_marked[slot] = 1'b1;
      total = total - mssum_pkg::TOTAL_W'(entry_value[slot]);
    endfunction

    function void log_mismatch(string msg);
      errors++;
      if (errors <= REPORT_LIMIT) $display("ERROR at %0t: %s", $time, msg);
    endfunction

    // Applies one accepted item to the table.
    function void note_item(logic [mssum_pkg::FUNC_W-1:0] f,
                            logic [mssum_pkg::LOAD_W-1:0] v,
                            logic [mssum_pkg::QIDX_W-1:0] qi,
                            logic [mssum_pkg::KCNT_W-1:0] k);
      int unsigned left;
      int cheapest;
      case (f)
        mssum_pkg::FUNC_CLEAR: begin
          foreach (entry_marked[i]) entry_marked[i] = 1'b0;
          loaded = 0;
          total = '0;
        end
        mssum_pkg::FUNC_LOAD: begin
          if (loaded < TABLE_DEPTH) begin
            entry_value[loaded] = v[VALUE_W-1:0];
            entry_marked[loaded] = 1'b0;
            total = total + mssum_pkg::TOTAL_W'(v[VALUE_W-1:0]);
            loaded++;
          end
        end
        mssum_pkg::FUNC_QUERY: begin
          if (qi < loaded && !entry_marked[qi]) strike(qi);
          left = k;
          while (left > 0) begin
            // Smallest unmarked value wins; a strict compare keeps the lower index on ties.
            cheapest = -1;
            for (int i = 0; i < loaded; i++) begin
              if (!entry_marked[i] &&
                  (cheapest < 0 || entry_value[i] < entry_value[cheapest])) begin
                cheapest = i;
              end
            end
            if (cheapest < 0) break;
            strike(cheapest);
            left--;
          end
          pending_totals.insert(pending_totals.size(), total);
        end
        default: begin
        end
      endcase
    endfunction

    // Compares one result with the oldest total owed.
    function void check_result(logic [mssum_pkg::TOTAL_W-1:0] got);
      logic [mssum_pkg::TOTAL_W-1:0] want;
      if (pending_totals.size() == 0) begin
        log_mismatch($sformatf("result %0d arrived with no query pending", got));
        return;
      end
      want = pending_totals.pop_front();
      if (got !== want) begin
        log_mismatch($sformatf("unmarked_total expected %0d, got %0d", want, got));
      end
    endfunction
  endclass

  unmarked_sum_tracker tracker = new();

  mark_smallest_unmarked_sum #(
    .ENTRIES(TABLE_DEPTH),
    .VALUE_BITS(VALUE_W)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .func(func),
    .load_value(load_value),
    .query_index(query_index),
    .mark_count(mark_count),
    .done(done),
    .unmarked_total(unmarked_total)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Results cannot be held off, so every strobe is checked in its own cycle.
  always @(posedge clk) begin
    if (!rst && done === 1'b1) tracker.check_result(unmarked_total);
  end

  // Ends a hung run.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Presents one item and holds it until the block takes it, then idles at random.
  task automatic send_item(input logic [mssum_pkg::FUNC_W-1:0] f,
                           input logic [mssum_pkg::LOAD_W-1:0] v,
                           input logic [mssum_pkg::QIDX_W-1:0] qi,
                           input logic [mssum_pkg::KCNT_W-1:0] k);
    start <= 1'b1;
    func <= f;
    load_value <= v;
    query_index <= qi;
    mark_count <= k;
    do @(posedge clk); while (busy);
    tracker.note_item(f, v, qi, k);
    if (f != FUNC_UNUSED) item_count++;
    if (!quiet_tail && $urandom_range(0, 15) < idle_odds) begin
      start <= 1'b0;
      func <= mssum_pkg::FUNC_W'($urandom_range(0, 3));
      load_value <= mssum_pkg::LOAD_W'($urandom);
      query_index <= mssum_pkg::QIDX_W'($urandom);
      mark_count <= mssum_pkg::KCNT_W'($urandom_range(0, 64));
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
  endtask

  // Value styles: full range, a few small values for ties, all ones, or extremes.
  function automatic logic [mssum_pkg::LOAD_W-1:0] pick_value(int unsigned style);
    case (style)
      0: return mssum_pkg::LOAD_W'($urandom);
      1: return mssum_pkg::LOAD_W'($urandom_range(0, 7));
      2: return '1;
      default: return ($urandom_range(0, 1) != 0) ? '1 : '0;
    endcase
  endfunction

  // Mostly a loaded index, sometimes any index.
  function automatic logic [mssum_pkg::QIDX_W-1:0] pick_index();
    if (tracker.loaded != 0 && $urandom_range(0, 3) != 0) begin
      return mssum_pkg::QIDX_W'($urandom_range(0, tracker.loaded - 1));
    end
    return mssum_pkg::QIDX_W'($urandom);
  endfunction

  // Mostly short mark runs, sometimes long ones up to the whole table.
  function automatic logic [mssum_pkg::KCNT_W-1:0] pick_count();
    case ($urandom_range(0, 9))
      6, 7: return mssum_pkg::KCNT_W'($urandom_range(0, 64));
      8: return mssum_pkg::KCNT_W'(64);
      9: return '0;
      default: return mssum_pkg::KCNT_W'($urandom_range(0, 3));
    endcase
  endfunction

  // One table life: usually a clear, a run of loads, then queries mixed with
  // late loads and dropped codes.
  task automatic run_sequence();
    int unsigned n_loads;
    int unsigned value_style;
    idle_odds = $urandom_range(0, 4);
    if ($urandom_range(0, 7) != 0) begin
      send_item(mssum_pkg::FUNC_CLEAR, mssum_pkg::LOAD_W'($urandom),
                mssum_pkg::QIDX_W'($urandom), mssum_pkg::KCNT_W'($urandom_range(0, 64)));
    end
    case ($urandom_range(0, 7))
      0: n_loads = TABLE_DEPTH + $urandom_range(0, 3);
      1: n_loads = $urandom_range(25, 63);
      default: n_loads = $urandom_range(1, 24);
    endcase
    value_style = $urandom_range(0, 3);
    repeat (n_loads) begin
      send_item(mssum_pkg::FUNC_LOAD, pick_value(value_style), mssum_pkg::QIDX_W'($urandom),
                mssum_pkg::KCNT_W'($urandom_range(0, 64)));
    end
    repeat ($urandom_range(1, 10)) begin
      case ($urandom_range(0, 9))
        0: send_item(mssum_pkg::FUNC_LOAD, pick_value(value_style),
                     mssum_pkg::QIDX_W'($urandom),
                     mssum_pkg::KCNT_W'($urandom_range(0, 64)));
        1: send_item(FUNC_UNUSED, mssum_pkg::LOAD_W'($urandom), mssum_pkg::QIDX_W'($urandom),
                     mssum_pkg::KCNT_W'($urandom_range(0, 64)));
        default: send_item(mssum_pkg::FUNC_QUERY, mssum_pkg::LOAD_W'($urandom),
                           pick_index(), pick_count());
      endcase
    end
  endtask

  initial begin
    rst <= 1'b1;
    start <= 1'b0;
    func <= mssum_pkg::FUNC_CLEAR;
    load_value <= '0;
    query_index <= '0;
    mark_count <= '0;
    item_count = 0;
    idle_odds = 0;
    quiet_tail = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Queries on an empty table, and a dropped code with every bit set.
    send_item(mssum_pkg::FUNC_QUERY, '0, '0, '0);
    send_item(mssum_pkg::FUNC_QUERY, '1, '1, mssum_pkg::KCNT_W'(64));
    send_item(FUNC_UNUSED, '1, '1, mssum_pkg::KCNT_W'(64));

    // Values with every bit low and high, and a repeated maximum.
    send_item(mssum_pkg::FUNC_LOAD, 16'hFFFF, '0, '0);
    send_item(mssum_pkg::FUNC_LOAD, 16'h0000, '0, '0);
    send_item(mssum_pkg::FUNC_LOAD, 16'h5555, '0, '0);
    send_item(mssum_pkg::FUNC_LOAD, 16'hAAAA, '0, '0);
    send_item(mssum_pkg::FUNC_LOAD, 16'h0001, '0, '0);
    send_item(mssum_pkg::FUNC_LOAD, 16'hFFFF, '0, '0);

    // Index beyond the loaded count, then marking by index and by size.
    send_item(mssum_pkg::FUNC_QUERY, '0, mssum_pkg::QIDX_W'(63), mssum_pkg::KCNT_W'(0));
    send_item(mssum_pkg::FUNC_QUERY, '0, mssum_pkg::QIDX_W'(2), mssum_pkg::KCNT_W'(0));
    send_item(mssum_pkg::FUNC_QUERY, '0, mssum_pkg::QIDX_W'(2), mssum_pkg::KCNT_W'(1));
    send_item(mssum_pkg::FUNC_QUERY, '0, mssum_pkg::QIDX_W'(0), mssum_pkg::KCNT_W'(1));

    // A late load that ties an unmarked value; the lower index must go first.
    send_item(mssum_pkg::FUNC_LOAD, 16'hAAAA, '0, '0);
    send_item(mssum_pkg::FUNC_QUERY, '0, mssum_pkg::QIDX_W'(63), mssum_pkg::KCNT_W'(1));

    // Mark count far beyond what is left, then a query with nothing unmarked.
    send_item(mssum_pkg::FUNC_QUERY, '0, mssum_pkg::QIDX_W'(6), mssum_pkg::KCNT_W'(64));
    send_item(mssum_pkg::FUNC_QUERY, '0, mssum_pkg::QIDX_W'(5), mssum_pkg::KCNT_W'(2));

    // Clear, query the empty table, and reuse it.
    send_item(mssum_pkg::FUNC_CLEAR, '1, '1, mssum_pkg::KCNT_W'(64));
    send_item(mssum_pkg::FUNC_QUERY, '0, '0, mssum_pkg::KCNT_W'(64));
    send_item(mssum_pkg::FUNC_LOAD, 16'h002A, '0, '0);
    send_item(mssum_pkg::FUNC_QUERY, '0, '0, '0);
    send_item(mssum_pkg::FUNC_CLEAR, '0, '0, '0);

    // Random table lives; the last stretch runs with no idle cycles.
    while (item_count < RANDOM_ITEMS) begin
      quiet_tail = (item_count + QUIET_TAIL_ITEMS >= RANDOM_ITEMS);
      run_sequence();
    end
    start <= 1'b0;

    // Wait for the owed totals, then long enough to catch stray results.
    while (tracker.pending_totals.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (tracker.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/mssum_pkg.sv
rtl/mssum_front.sv
rtl/mssum_fifo.sv
rtl/mssum_back.sv
rtl/mark_smallest_unmarked_sum.sv
verif/tb_mark_smallest_unmarked_sum.sv
